/* src/tcs_pkg.sv */
// tridiagonal solver package: result status codes, widths and q16.16 helpers
// no dependencies
package tcs_pkg;

   localparam int DataWidth = 32;
   localparam int IndexWidth = 6;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ZERO_PIVOT = 2'd1,
      STATUS_OVERFLOW   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_SUB   = 2'd0,
      REG_MAIN  = 2'd1,
      REG_SUPER = 2'd2
   } reg_index_type;

   // controller to datapath
   typedef struct packed {
      logic fwd_first;   // store d[0] = main, y[0] = r
      logic fwd_start;   // start forward elimination step
      logic fwd_zero;    // store zeros at current row
      logic back_start;  // start back substitution row
      logic back_top;    // top row: numerator is y itself
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic busy;
      logic done;        // one-cycle pulse at end of a step
      logic pivot_zero;  // pivot written by the step was zero
   } dp_status_type;

   // saturate a 64-bit signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // product >> 16 rounding toward minus infinity, saturated
   function automatic logic signed [31:0] qmul_fix(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> 16;
      return sat32(s);
   endfunction

   function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] d;
      d = 64'(a) - 64'(b);
      return sat32(d);
   endfunction

endpackage

/* src/tcs_stream_if.sv */
// valid/ready channel interface with generic payload
// depends on nothing
interface tcs_stream_if #(parameter int Width = 33);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

/* src/tcs_ram.sv */
// generic single-port write, single read ram with registered read data
// no dependencies
module tcs_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* src/tcs_divider.sv */
// signed q16.16 divider, radix 2 restoring, one quotient bit per cycle
// uses tcs_pkg for saturation
module tcs_divider import tcs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quot
);
   // |num|*65536 fits 48 bits; quotient magnitude up to 48 bits
   logic [47:0] rem_ff, rem_in;
   logic [47:0] q_ff, q_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [47:0] dividend;
   logic [31:0] num_mag;
   logic [48:0] trial;
   logic [47:0] rem_sh;
   logic signed [63:0] q_signed;

   always_comb begin
      num_mag  = num[31] ? 32'(-num) : num;
      dividend = {num_mag, 16'h0};
      rem_in = rem_ff; q_in = q_ff; den_in = den_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      rem_sh = {rem_ff[46:0], q_ff[47]};
      trial  = {1'b0, rem_sh} - {17'h0, den_ff};
      if (start) begin
         rem_in = 48'h0;
         q_in   = dividend;
         den_in = den[31] ? 32'(-den) : den;
         neg_in = num[31] ^ den[31];
         cnt_in = 6'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[48]) begin
            rem_in = trial[47:0];
            q_in   = {q_ff[46:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign q_signed = neg_ff ? -64'($unsigned(q_ff)) : 64'($unsigned(q_ff));
   assign quot = sat32(q_signed);
   assign done = done_ff;
endmodule

/* src/tcs_datapath.sv */
// datapath: pivot and work rams, divider, multiplier and subtract steps
// uses tcs_pkg, tcs_ram, tcs_divider
module tcs_datapath import tcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [IndexWidth-1:0] row,
   input  logic signed [31:0]    rhs,
   input  logic signed [31:0]    reg_sub,
   input  logic signed [31:0]    reg_main,
   input  logic signed [31:0]    reg_super,
   output dp_status_type         status,
   output logic signed [31:0]    x_value
);
   typedef enum logic [3:0] {
      S_IDLE, S_FRD, S_FDIV, S_FMUL1, S_FMUL2, S_FWR,
      S_BRD, S_BMUL, S_BSUB, S_BDIV
   } dp_state_type;

   dp_state_type state_ff;
   logic [IndexWidth-1:0] row_ff;
   logic signed [31:0] rhs_ff;
   logic signed [31:0] t_ff, x_ff, d_ff, y_ff, num_ff;
   logic signed [63:0] prod_ff;
   logic               done_ff, zero_ff;
   logic               top_ff;

   logic                  wr_en;
   logic [IndexWidth-1:0] wr_addr, rd_addr;
   logic [31:0]           piv_wdata, work_wdata, piv_rdata, work_rdata;
   logic                  div_start, div_done;
   logic signed [31:0]    div_num, div_den, div_q;
   logic signed [31:0]    mul_a, mul_b;
   logic signed [63:0]    mul_p;
   logic                  st_wr;
   logic signed [31:0]    st_d, st_y;

   assign rd_addr = (state_ff == S_IDLE && cmd.fwd_start) ? row - 6'd1 : row_ff;

   tcs_ram #(.Width(DataWidth), .Depth(64)) u_pivot (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(piv_wdata),
      .rd_addr(rd_addr), .rd_data(piv_rdata));
   tcs_ram #(.Width(DataWidth), .Depth(64)) u_work (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(work_wdata),
      .rd_addr(rd_addr), .rd_data(work_rdata));

   tcs_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quot(div_q));

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      div_start = 1'b0; div_num = reg_sub; div_den = piv_rdata;
      mul_a = t_ff; mul_b = reg_super;
      st_wr = 1'b0; st_d = 32'sd0; st_y = 32'sd0;
      case (state_ff)
         S_IDLE: begin
            if (cmd.fwd_first) begin
               st_wr = 1'b1; st_d = reg_main; st_y = rhs;
            end else if (cmd.fwd_zero) begin
               st_wr = 1'b1;
            end
         end
         S_FRD: div_start = 1'b1;
         S_FMUL2: begin mul_a = t_ff; mul_b = y_ff; end
         S_FWR: begin
            st_wr = 1'b1;
            st_d  = d_ff;
            st_y  = qsub(rhs_ff, qmul_fix(prod_ff));
         end
         S_BMUL: begin mul_a = reg_super; mul_b = x_ff; end
         S_BSUB: begin
            div_start = 1'b1;
            div_num = top_ff ? y_ff : qsub(y_ff, qmul_fix(prod_ff));
            div_den = d_ff;
         end
         default: ;
      endcase
      wr_en = st_wr; wr_addr = (state_ff == S_IDLE) ? row : row_ff;
      piv_wdata = st_d; work_wdata = st_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
         zero_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (cmd.fwd_first || cmd.fwd_zero) begin
                  done_ff <= 1'b1;
                  zero_ff <= cmd.fwd_first && (reg_main == 32'sd0);
               end else if (cmd.fwd_start) begin
                  state_ff <= S_FRD;
                  row_ff <= row; rhs_ff <= rhs;
               end else if (cmd.back_start) begin
                  state_ff <= S_BRD;
                  row_ff <= row; top_ff <= cmd.back_top;
               end
            end
            S_FRD: begin
               y_ff <= work_rdata;
               state_ff <= S_FDIV;
            end
            S_FDIV: if (div_done) begin
               t_ff <= div_q;
               state_ff <= S_FMUL1;
            end
            S_FMUL1: begin
               d_ff <= qsub(reg_main, qmul_fix(mul_p));
               state_ff <= S_FMUL2;
            end
            S_FMUL2: begin
               prod_ff <= mul_p;
               state_ff <= S_FWR;
            end
            S_FWR: begin
               zero_ff <= (d_ff == 32'sd0);
               done_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_BRD: begin
               // read wait: rd_addr held at row_ff, read data is valid in S_BMUL
               state_ff <= S_BMUL;
            end
            S_BMUL: begin
               d_ff <= piv_rdata; y_ff <= work_rdata;
               prod_ff <= mul_p;
               state_ff <= S_BSUB;
            end
            S_BSUB: state_ff <= S_BDIV;
            S_BDIV: if (div_done) begin
               x_ff <= div_q;
               done_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign status.busy = (state_ff != S_IDLE);
   assign status.done = done_ff;
   assign status.pivot_zero = zero_ff;
   assign x_value = x_ff;
endmodule

/* src/tcs_controller.sv */
// controller: run bookkeeping, handshakes and sequencing of the datapath
// uses tcs_pkg
module tcs_controller import tcs_pkg::*; #(
   parameter int MaxSize = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IndexWidth-1:0] rsp_index,
   output status_type            rsp_status,
   output logic                  rsp_last,
   output logic                  rsp_from_dp,
   output dp_cmd_type            cmd,
   output logic [IndexWidth-1:0] row,
   input  dp_status_type         dp_status
);
   typedef enum logic [2:0] {
      C_IDLE, C_FWD, C_DECIDE, C_BACK, C_OUT
   } ctl_state_type;

   ctl_state_type state_ff;
   logic [6:0] count_ff;
   logic       zero_ff, ovf_ff, last_ff;
   logic [IndexWidth-1:0] row_ff;
   logic       rsp_valid_ff, from_dp_ff, rlast_ff;
   status_type status_ff;
   logic       launched_ff;
   logic       accept, counted;

   assign req_ready = (state_ff == C_IDLE);
   assign accept = req_valid && req_ready;
   assign counted = !ovf_ff && (count_ff < 7'(MaxSize));

   always_comb begin
      cmd = '0;
      row = count_ff[IndexWidth-1:0];
      if (accept && counted) begin
         if (count_ff == 7'd0) cmd.fwd_first = 1'b1;
         else if (zero_ff) cmd.fwd_zero = 1'b1;
         else cmd.fwd_start = 1'b1;
      end
      if (state_ff == C_BACK && !launched_ff) begin
         cmd.back_start = 1'b1;
         cmd.back_top = (row_ff == count_ff[IndexWidth-1:0] - 6'd1);
         row = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         count_ff <= 7'd0;
         zero_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         launched_ff <= 1'b0;
      end else begin
         case (state_ff)
            C_IDLE: if (accept) begin
               last_ff <= req_last;
               if (counted) begin
                  count_ff <= count_ff + 7'd1;
                  state_ff <= C_FWD;
               end else begin
                  ovf_ff <= 1'b1;
                  state_ff <= req_last ? C_DECIDE : C_IDLE;
               end
            end
            C_FWD: if (dp_status.done) begin
               if (dp_status.pivot_zero) zero_ff <= 1'b1;
               state_ff <= last_ff ? C_DECIDE : C_IDLE;
            end
            C_DECIDE: begin
               if (ovf_ff || zero_ff || count_ff == 7'd0) begin
                  rsp_valid_ff <= 1'b1;
                  from_dp_ff <= 1'b0;
                  status_ff <= ovf_ff ? STATUS_OVERFLOW : STATUS_ZERO_PIVOT;
                  row_ff <= '0;
                  rlast_ff <= 1'b1;
                  state_ff <= C_OUT;
               end else begin
                  row_ff <= 6'(count_ff - 7'd1);
                  launched_ff <= 1'b0;
                  state_ff <= C_BACK;
               end
            end
            C_BACK: begin
               launched_ff <= 1'b1;
               if (dp_status.done) begin
                  launched_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  from_dp_ff <= 1'b1;
                  status_ff <= STATUS_OK;
                  rlast_ff <= (row_ff == '0);
                  state_ff <= C_OUT;
               end
            end
            C_OUT: if (rsp_ready) begin
               rsp_valid_ff <= 1'b0;
               if (rlast_ff) begin
                  count_ff <= 7'd0;
                  zero_ff <= 1'b0;
                  ovf_ff <= 1'b0;
                  state_ff <= C_IDLE;
               end else begin
                  row_ff <= row_ff - 6'd1;
                  state_ff <= C_BACK;
               end
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = row_ff;
   assign rsp_status = status_ff;
   assign rsp_last = rlast_ff;
   assign rsp_from_dp = from_dp_ff;
endmodule

/* src/tridiagonal_constant_solver.sv */
// top level of the constant-diagonal tridiagonal solver (thomas algorithm)
// uses tcs_pkg, tcs_stream_if, tcs_controller, tcs_datapath
//
//  channel  dir  payload                                          beat when
//  req      in   rhs_value[31:0], rhs_last                        valid & ready
//  rsp      out  solution_value, solution_index, status, last     valid & ready
//  csr      in   index[1:0], data[31:0]                           valid & ready
//
// a forward step is dominated by the 48-step radix-2 divider
// each back substitution row is again dominated by the divider
// one item at a time: req is ready only between steps, not during back substitution
// rsp holds a result until taken; the next row starts after the beat
// synchronous active high reset clears counts and flags; the rams need no clearing
module tridiagonal_constant_solver import tcs_pkg::*; #(
   parameter int MaxSize = 64
) (
   input logic clock,
   input logic reset,
   tcs_stream_if.sink   req,
   tcs_stream_if.source rsp,
   tcs_stream_if.sink   csr
);
   logic signed [31:0] sub_ff, main_ff, super_ff;
   dp_cmd_type         cmd;
   dp_status_type      dp_status;
   logic [IndexWidth-1:0] row, rsp_index;
   status_type         rsp_status;
   logic               rsp_last, from_dp;
   logic signed [31:0] x_value;

   // registers are always writable
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= 32'sd0;
         main_ff  <= 32'sd65536;
         super_ff <= 32'sd0;
      end else if (csr.valid) begin
         case (csr.data[33:32])
            REG_SUB:   sub_ff   <= csr.data[31:0];
            REG_MAIN:  main_ff  <= csr.data[31:0];
            REG_SUPER: super_ff <= csr.data[31:0];
            default: ;
         endcase
      end
   end

   tcs_controller #(.MaxSize(MaxSize)) u_ctl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_last(req.data[32]),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_index(rsp_index),
      .rsp_status(rsp_status), .rsp_last(rsp_last), .rsp_from_dp(from_dp),
      .cmd(cmd), .row(row), .dp_status(dp_status));

   tcs_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .row(row),
      .rhs(req.data[31:0]), .reg_sub(sub_ff), .reg_main(main_ff),
      .reg_super(super_ff), .status(dp_status), .x_value(x_value));

   // rsp payload: {last, status, index, value}
   assign rsp.data = {rsp_last, rsp_status, rsp_index,
                      from_dp ? x_value : 32'sd0};
endmodule
